>>> sv/ttcc_pkg.sv
`default_nettype none

package ttcc_pkg;

    // cell geometry in pixels
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int TAB_CELLS    = 4;
    localparam int TAB_STEP     = TAB_CELLS * GLYPH_WIDTH;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int COORD_W  = 12;
    localparam int SCREEN_W = 13;
    localparam int COLOR_W  = 24;
    localparam int CHAR_W   = 8;
    localparam int GLYPH_W  = 7;
    localparam int SCROLL_W = 9;
    localparam int CFG_AW   = 1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_CTRL_LAST = 8'h19;
    localparam logic [CHAR_W-1:0] CH_DEL       = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_NL        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // input opcodes
    localparam logic OP_PRINT  = 1'b0;
    localparam logic OP_SET    = 1'b1;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

    // classified command
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SET,
        CMD_GLYPH,
        CMD_SPACE,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_BACKSPACE,
        CMD_TAB
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_BLANK = 2'd2
    } action_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } entry_t;

    typedef struct packed {
        logic [SCROLL_W-1:0] scroll_lines;
        action_t             cell_action;
        logic [COORD_W-1:0]  cell_x;
        logic [COORD_W-1:0]  cell_y;
        logic [GLYPH_W-1:0]  glyph_code;
        logic [COLOR_W-1:0]  glyph_color;
        logic [COORD_W-1:0]  prev_cursor_x;
        logic [COORD_W-1:0]  prev_cursor_y;
        logic [COORD_W-1:0]  cursor_x;
        logic [COORD_W-1:0]  cursor_y;
    } result_t;

endpackage

`default_nettype wire

>>> sv/ttcc_front.sv
`default_nettype none

module ttcc_front
(
    input  wire logic                          opcode,
    input  wire logic [ttcc_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [ttcc_pkg::COLOR_W-1:0]  text_color,
    input  wire logic [ttcc_pkg::COORD_W-1:0]  new_x,
    input  wire logic [ttcc_pkg::COORD_W-1:0]  new_y,
    output ttcc_pkg::entry_t                   entry
);

    ttcc_pkg::cmd_t cmd;

    always_comb
    begin
        cmd = ttcc_pkg::CMD_NOP;
        if (opcode == ttcc_pkg::OP_SET)
        begin
            cmd = ttcc_pkg::CMD_SET;
        end
        else if (char_code inside {[ttcc_pkg::CH_CTRL_LAST + 8'd1 : ttcc_pkg::CH_DEL - 8'd1]})
        begin
            cmd = (char_code == ttcc_pkg::CH_SPACE) ? ttcc_pkg::CMD_SPACE
                                                    : ttcc_pkg::CMD_GLYPH;
        end
        else
        begin
            case (char_code)
                ttcc_pkg::CH_NL:  cmd = ttcc_pkg::CMD_NEWLINE;
                ttcc_pkg::CH_CR:  cmd = ttcc_pkg::CMD_RETURN;
                ttcc_pkg::CH_BS:  cmd = ttcc_pkg::CMD_BACKSPACE;
                ttcc_pkg::CH_TAB: cmd = ttcc_pkg::CMD_TAB;
                default:          cmd = ttcc_pkg::CMD_NOP;
            endcase
        end
    end

    always_comb
    begin
        entry.cmd   = cmd;
        entry.glyph = char_code[ttcc_pkg::GLYPH_W-1:0];
        // color only travels with a drawn glyph
        entry.color = (cmd == ttcc_pkg::CMD_GLYPH) ? text_color : '0;
        entry.pos_x = new_x;
        entry.pos_y = new_y;
    end

endmodule

`default_nettype wire

>>> sv/ttcc_queue.sv
`default_nettype none

module ttcc_queue
#(
    parameter int DEPTH = ttcc_pkg::QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ttcc_pkg::entry_t push_entry,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output ttcc_pkg::entry_t      pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttcc_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/ttcc_back.sv
`default_nettype none

module ttcc_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ttcc_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [ttcc_pkg::SCREEN_W-1:0] cfg_wdata,
    input  wire logic                          q_valid,
    input  wire ttcc_pkg::entry_t              q_entry,
    output logic                               q_pop,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output ttcc_pkg::result_t                  res
);

    localparam int SW = ttcc_pkg::SCREEN_W;
    localparam int EW = ttcc_pkg::SCREEN_W + 1;
    localparam int CW = ttcc_pkg::COORD_W;

    typedef struct packed {
        logic                          hit;
        logic [ttcc_pkg::SCROLL_W-1:0] lines;
        logic [SW-1:0]                 row;
    } fit_t;

    logic [SW-1:0]      width_reg, height_reg;
    logic [CW-1:0]      cur_x_reg, cur_y_reg;
    logic [CW-1:0]      cur_x_next, cur_y_next;
    logic               out_valid_reg;
    ttcc_pkg::result_t  res_reg, res_next;

    logic [SW-1:0] x0, y0, nx, ny, wx, wy, row_end;
    fit_t          fit;

    // brings a row back on screen, whole text lines at a time
    function automatic fit_t scroll_fit(input logic [SW-1:0] row, input logic [SW-1:0] height);
        logic [EW-1:0] bottom;
        logic [EW-1:0] excess;
        logic [EW-1:0] nlines;
        logic [EW-1:0] step;
        fit_t          f;
        bottom = {1'b0, row} + EW'(ttcc_pkg::GLYPH_HEIGHT);
        excess = bottom - {1'b0, height};
        nlines = (excess + EW'(ttcc_pkg::GLYPH_HEIGHT - 1)) / EW'(ttcc_pkg::GLYPH_HEIGHT);
        step   = EW'(nlines * EW'(ttcc_pkg::GLYPH_HEIGHT));
        f.hit  = (bottom > {1'b0, height});
        f.lines = (nlines > EW'((1 << ttcc_pkg::SCROLL_W) - 1)) ? '1
                                                                 : nlines[ttcc_pkg::SCROLL_W-1:0];
        f.row  = (step > {1'b0, row}) ? '0 : SW'({1'b0, row} - step);
        return f;
    endfunction

    function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
        return v[SW-1] ? '1 : v[CW-1:0];
    endfunction

    assign q_pop     = q_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        x0       = {1'b0, cur_x_reg};
        y0       = {1'b0, cur_y_reg};
        nx       = x0;
        ny       = y0;
        wx       = x0;
        wy       = y0;
        fit      = '0;
        row_end  = SW'((width_reg / SW'(ttcc_pkg::GLYPH_WIDTH)) * SW'(ttcc_pkg::GLYPH_WIDTH));
        res_next = '0;
        res_next.cell_action   = ttcc_pkg::ACT_NONE;
        res_next.prev_cursor_x = cur_x_reg;
        res_next.prev_cursor_y = cur_y_reg;

        case (q_entry.cmd)
            ttcc_pkg::CMD_SET:
            begin
                nx = {1'b0, q_entry.pos_x};
                ny = {1'b0, q_entry.pos_y};
            end
            ttcc_pkg::CMD_GLYPH, ttcc_pkg::CMD_SPACE:
            begin
                // wrap past the right edge
                if (x0 + SW'(ttcc_pkg::GLYPH_WIDTH) > width_reg)
                begin
                    wx = '0;
                    wy = y0 + SW'(ttcc_pkg::GLYPH_HEIGHT);
                end
                fit = scroll_fit(wy, height_reg);
                if (fit.hit)
                begin
                    wx = '0;
                    wy = fit.row;
                    res_next.scroll_lines = fit.lines;
                end
                if (q_entry.cmd == ttcc_pkg::CMD_GLYPH)
                begin
                    res_next.cell_action = ttcc_pkg::ACT_DRAW;
                    res_next.cell_x      = sat(wx);
                    res_next.cell_y      = sat(wy);
                    res_next.glyph_code  = q_entry.glyph;
                    res_next.glyph_color = q_entry.color;
                end
                nx = wx + SW'(ttcc_pkg::GLYPH_WIDTH);
                ny = wy;
            end
            ttcc_pkg::CMD_NEWLINE:
            begin
                wy  = y0 + SW'(ttcc_pkg::GLYPH_HEIGHT);
                fit = scroll_fit(wy, height_reg);
                nx  = '0;
                ny  = fit.hit ? fit.row : wy;
                if (fit.hit)
                begin
                    res_next.scroll_lines = fit.lines;
                end
            end
            ttcc_pkg::CMD_RETURN:
            begin
                nx = '0;
            end
            ttcc_pkg::CMD_BACKSPACE:
            begin
                if (x0 >= SW'(ttcc_pkg::GLYPH_WIDTH))
                begin
                    nx = x0 - SW'(ttcc_pkg::GLYPH_WIDTH);
                    res_next.cell_action = ttcc_pkg::ACT_BLANK;
                end
                else if (y0 >= SW'(ttcc_pkg::GLYPH_HEIGHT))
                begin
                    // last whole cell of the line above
                    nx = (row_end >= SW'(ttcc_pkg::GLYPH_WIDTH))
                         ? row_end - SW'(ttcc_pkg::GLYPH_WIDTH) : '0;
                    ny = y0 - SW'(ttcc_pkg::GLYPH_HEIGHT);
                    res_next.cell_action = ttcc_pkg::ACT_BLANK;
                end
                if (res_next.cell_action == ttcc_pkg::ACT_BLANK)
                begin
                    res_next.cell_x = sat(nx);
                    res_next.cell_y = sat(ny);
                end
            end
            ttcc_pkg::CMD_TAB:
            begin
                if ({1'b0, x0} + EW'(ttcc_pkg::TAB_STEP) < {1'b0, width_reg})
                begin
                    nx = x0 + SW'(ttcc_pkg::TAB_STEP);
                end
            end
            default:
            begin
                nx = x0;
            end
        endcase

        cur_x_next        = sat(nx);
        cur_y_next        = sat(ny);
        res_next.cursor_x = cur_x_next;
        res_next.cursor_y = cur_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ttcc_pkg::SCREEN_WIDTH_RST;
            height_reg    <= ttcc_pkg::SCREEN_HEIGHT_RST;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    ttcc_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                    ttcc_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                    default:                     width_reg  <= width_reg;
                endcase
            end
            if (q_pop)
            begin
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/text_console_cursor_engine_unit.sv
`default_nettype none

// text console cursor engine: keeps a pixel cursor and turns each character
// item into one cell command (scroll count, draw or blank cell, glyph and
// color) together with the cursor before and after the item. a set-cursor
// item loads a new position. the front classifies each accepted item into a
// command and writes it into a small queue; the back pops one command per
// cycle while the output register is free or taken, updates the cursor and
// loads the output register. one item per cycle sustained without output
// stalls; an accepted item is written into the queue, then popped into the
// output register, where its result is offered. the cursor update loop in
// the back sets that rate. in_ready drops only when the queue is full. the
// user must write screen width and height through the cfg port only while
// idle; the block does not enforce this. they reset to 1024 by 768 pixels

module text_console_cursor_engine_unit
#(
    parameter int QUEUE_DEPTH = ttcc_pkg::QUEUE_DEPTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [ttcc_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [ttcc_pkg::SCREEN_W-1:0]  cfg_wdata,

    // input item channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           opcode,
    input  wire logic [ttcc_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [ttcc_pkg::COLOR_W-1:0]   text_color,
    input  wire logic [ttcc_pkg::COORD_W-1:0]   new_x,
    input  wire logic [ttcc_pkg::COORD_W-1:0]   new_y,

    // result item channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ttcc_pkg::SCROLL_W-1:0]       scroll_lines,
    output logic [1:0]                          cell_action,
    output logic [ttcc_pkg::COORD_W-1:0]        cell_x,
    output logic [ttcc_pkg::COORD_W-1:0]        cell_y,
    output logic [ttcc_pkg::GLYPH_W-1:0]        glyph_code,
    output logic [ttcc_pkg::COLOR_W-1:0]        glyph_color,
    output logic [ttcc_pkg::COORD_W-1:0]        prev_cursor_x,
    output logic [ttcc_pkg::COORD_W-1:0]        prev_cursor_y,
    output logic [ttcc_pkg::COORD_W-1:0]        cursor_x,
    output logic [ttcc_pkg::COORD_W-1:0]        cursor_y
);

    ttcc_pkg::entry_t  front_entry;   // classified item from the front
    ttcc_pkg::entry_t  q_entry;       // head of the queue
    logic              q_valid;
    logic              q_pop;
    ttcc_pkg::result_t res;

    // decode opcode and character into a command
    ttcc_front u_front
    (
        .opcode     (opcode),
        .char_code  (char_code),
        .text_color (text_color),
        .new_x      (new_x),
        .new_y      (new_y),
        .entry      (front_entry)
    );

    // decouples acceptance from execution
    ttcc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_entry (front_entry),
        .push_ready (in_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    // cursor state, wrap, scroll and output register
    ttcc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    // result fields
    assign scroll_lines  = res.scroll_lines;
    assign cell_action   = res.cell_action;
    assign cell_x        = res.cell_x;
    assign cell_y        = res.cell_y;
    assign glyph_code    = res.glyph_code;
    assign glyph_color   = res.glyph_color;
    assign prev_cursor_x = res.prev_cursor_x;
    assign prev_cursor_y = res.prev_cursor_y;
    assign cursor_x      = res.cursor_x;
    assign cursor_y      = res.cursor_y;

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;

    import ttcc_pkg::*;

    // run length and bounds
    localparam int          PHASES       = 24;
    localparam int          PHASE_ITEMS  = 48;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          HOLD_CYCLES  = 250;
    localparam longint      COORD_MAX    = (1 << COORD_W) - 1;
    localparam longint      SCROLL_MAX   = (1 << SCROLL_W) - 1;

    // one character item as offered on the input channel
    typedef struct {
        logic               op;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
    } char_item_t;

    // tracks the cursor and screen size on its own and keeps the cell
    // commands still owed by the block, oldest first
    class cursor_tracker;
        int unsigned width_px;
        int unsigned height_px;
        int unsigned col_px;
        int unsigned row_px;
        result_t     owed_cells[$];
        int unsigned mismatches;
        int unsigned cells_checked;

        function new();
            width_px      = SCREEN_WIDTH_RST;
            height_px     = SCREEN_HEIGHT_RST;
            col_px        = 0;
            row_px        = 0;
            mismatches    = 0;
            cells_checked = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, int unsigned value);
            if (idx == REG_SCREEN_WIDTH)
                width_px = value;
            else
                height_px = value;
        endfunction

        function longint clamp_coord(longint v);
            if (v < 0)
                return 0;
            if (v > COORD_MAX)
                return COORD_MAX;
            return v;
        endfunction

        // pulls the row back on screen; scroll count or -1 when none needed
        function longint fit_row(inout longint row);
            longint excess;
            longint lines;
            excess = row + GLYPH_HEIGHT - longint'(height_px);
            if (excess <= 0)
                return -1;
            lines = (excess + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
            row -= lines * GLYPH_HEIGHT;
            if (row < 0)
                row = 0;
            return (lines > SCROLL_MAX) ? SCROLL_MAX : lines;
        endfunction

        // cell command for one character, advancing the cursor
        function result_t next_cell(char_item_t it);
            longint  x;
            longint  y;
            longint  w;
            longint  s;
            result_t r;
            r = '0;
            x = col_px;
            y = row_px;
            w = width_px;
            r.prev_cursor_x = COORD_W'(col_px);
            r.prev_cursor_y = COORD_W'(row_px);
            if (it.op == OP_SET)
            begin
                x = it.nx;
                y = it.ny;
            end
            else if (it.ch > CH_CTRL_LAST && it.ch < CH_DEL)
            begin
                // wrap at the right edge, then scroll, then draw
                if (x + GLYPH_WIDTH > w)
                begin
                    x = 0;
                    y += GLYPH_HEIGHT;
                end
                s = fit_row(y);
                if (s >= 0)
                begin
                    x = 0;
                    r.scroll_lines = SCROLL_W'(s);
                end
                if (it.ch != CH_SPACE)
                begin
                    r.cell_action = ACT_DRAW;
                    r.cell_x      = COORD_W'(clamp_coord(x));
                    r.cell_y      = COORD_W'(clamp_coord(y));
                    r.glyph_code  = it.ch[GLYPH_W-1:0];
                    r.glyph_color = it.color;
                end
                x += GLYPH_WIDTH;
            end
            else if (it.ch == CH_NL)
            begin
                y += GLYPH_HEIGHT;
                x = 0;
                s = fit_row(y);
                if (s >= 0)
                    r.scroll_lines = SCROLL_W'(s);
            end
            else if (it.ch == CH_CR)
            begin
                x = 0;
            end
            else if (it.ch == CH_BS)
            begin
                if (x >= GLYPH_WIDTH || y >= GLYPH_HEIGHT)
                begin
                    if (x >= GLYPH_WIDTH)
                        x -= GLYPH_WIDTH;
                    else
                    begin
                        // last whole cell of the line above
                        x = (w / GLYPH_WIDTH) * GLYPH_WIDTH - GLYPH_WIDTH;
                        if (x < 0)
                            x = 0;
                        y -= GLYPH_HEIGHT;
                    end
                    r.cell_action = ACT_BLANK;
                    r.cell_x      = COORD_W'(clamp_coord(x));
                    r.cell_y      = COORD_W'(clamp_coord(y));
                end
            end
            else if (it.ch == CH_TAB)
            begin
                if (x + TAB_STEP < w)
                    x += TAB_STEP;
            end
            col_px = int'(clamp_coord(x));
            row_px = int'(clamp_coord(y));
            r.cursor_x = COORD_W'(col_px);
            r.cursor_y = COORD_W'(row_px);
            return r;
        endfunction

        function void take_char(char_item_t it);
            owed_cells.push_back(next_cell(it));
        endfunction

        function int unsigned owed();
            return owed_cells.size();
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned seen);
            if (want != seen)
            begin
                mismatches++;
                $display("%0t mismatch on %s: expected %0d, got %0d",
                         $time, name, want, seen);
            end
        endfunction

        function void check_cell(result_t seen);
            result_t want;
            if (owed_cells.size() == 0)
            begin
                mismatches++;
                $display("%0t cell command with none outstanding", $time);
                return;
            end
            want = owed_cells.pop_front();
            cells_checked++;
            compare_field("scroll_lines", want.scroll_lines, seen.scroll_lines);
            compare_field("cell_action", want.cell_action, seen.cell_action);
            compare_field("cell_x", want.cell_x, seen.cell_x);
            compare_field("cell_y", want.cell_y, seen.cell_y);
            compare_field("glyph_code", want.glyph_code, seen.glyph_code);
            compare_field("glyph_color", want.glyph_color, seen.glyph_color);
            compare_field("prev_cursor_x", want.prev_cursor_x, seen.prev_cursor_x);
            compare_field("prev_cursor_y", want.prev_cursor_y, seen.prev_cursor_y);
            compare_field("cursor_x", want.cursor_x, seen.cursor_x);
            compare_field("cursor_y", want.cursor_y, seen.cursor_y);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_AW-1:0]      cfg_addr;
    logic [SCREEN_W-1:0]    cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic                   opcode;
    logic [CHAR_W-1:0]      char_code;
    logic [COLOR_W-1:0]     text_color;
    logic [COORD_W-1:0]     new_x;
    logic [COORD_W-1:0]     new_y;
    logic                   out_valid;
    logic                   out_ready;
    logic [SCROLL_W-1:0]    scroll_lines;
    logic [1:0]             cell_action;
    logic [COORD_W-1:0]     cell_x;
    logic [COORD_W-1:0]     cell_y;
    logic [GLYPH_W-1:0]     glyph_code;
    logic [COLOR_W-1:0]     glyph_color;
    logic [COORD_W-1:0]     prev_cursor_x;
    logic [COORD_W-1:0]     prev_cursor_y;
    logic [COORD_W-1:0]     cursor_x;
    logic [COORD_W-1:0]     cursor_y;

    cursor_tracker tracker = new();

    // idling odds in percent, hold-off counter owned by the output side
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_left    = 0;
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;

    text_console_cursor_engine_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .char_code     (char_code),
        .text_color    (text_color),
        .new_x         (new_x),
        .new_y         (new_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scroll_lines  (scroll_lines),
        .cell_action   (cell_action),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .glyph_code    (glyph_code),
        .glyph_color   (glyph_color),
        .prev_cursor_x (prev_cursor_x),
        .prev_cursor_y (prev_cursor_y),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: values read right after the edge are the ones the edge
    // sampled, so an accepted cell command is checked here; ready for the
    // next edge is chosen by the stall odds or by a pending hold-off
    initial
    begin : cell_sink
        result_t seen;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen               = '0;
                seen.scroll_lines  = scroll_lines;
                seen.cell_action   = action_t'(cell_action);
                seen.cell_x        = cell_x;
                seen.cell_y        = cell_y;
                seen.glyph_code    = glyph_code;
                seen.glyph_color   = glyph_color;
                seen.prev_cursor_x = prev_cursor_x;
                seen.prev_cursor_y = prev_cursor_y;
                seen.cursor_x      = cursor_x;
                seen.cursor_y      = cursor_y;
                tracker.check_cell(seen);
            end
            if (hold_left > 0)
            begin
                // long hold-off: the queue fills and in_ready must drop
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // offers one item after random idle cycles and holds it until taken
    task automatic send_item(input char_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= it.op;
        char_code  <= it.ch;
        text_color <= it.color;
        new_x      <= it.nx;
        new_y      <= it.ny;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_char(it);
        items_sent++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] color);
        char_item_t it;
        it.op    = OP_PRINT;
        it.ch    = ch;
        it.color = color;
        it.nx    = COORD_W'($urandom);
        it.ny    = COORD_W'($urandom);
        send_item(it);
    endtask

    // the character byte is random on purpose: a set must ignore it
    task automatic send_move(input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        char_item_t it;
        it.op    = OP_SET;
        it.ch    = CHAR_W'($urandom);
        it.color = COLOR_W'($urandom);
        it.nx    = x;
        it.ny    = y;
        send_item(it);
    endtask

    // mostly text with some line control, a few cursor moves and noise
    function automatic char_item_t random_item(int unsigned w, int unsigned h);
        char_item_t  it;
        int unsigned pick;
        it.op    = OP_PRINT;
        it.ch    = CHAR_W'($urandom);
        it.color = COLOR_W'($urandom);
        it.nx    = COORD_W'($urandom);
        it.ny    = COORD_W'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 6)
        begin
            it.op = OP_SET;
            // half the moves land on screen, the rest anywhere
            if ($urandom_range(0, 1) == 0)
            begin
                it.nx = COORD_W'($urandom_range(0, w - 1));
                it.ny = COORD_W'($urandom_range(0, h - 1));
            end
        end
        else if (pick < 62)
            it.ch = CHAR_W'($urandom_range(CH_SPACE + 1, CH_DEL - 1));
        else if (pick < 68)
            it.ch = CH_SPACE;
        else if (pick < 76)
            it.ch = CH_NL;
        else if (pick < 80)
            it.ch = CH_CR;
        else if (pick < 88)
            it.ch = CH_BS;
        else if (pick < 93)
            it.ch = CH_TAB;
        return it;
    endfunction

    // idle input, wait for every owed command, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.owed() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // writes both screen registers on back-to-back edges
    task automatic set_screen(input int unsigned w, input int unsigned h);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SCREEN_WIDTH;
        cfg_wdata <= SCREEN_W'(w);
        @(posedge clk);
        cfg_addr  <= REG_SCREEN_HEIGHT;
        cfg_wdata <= SCREEN_W'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_reg(REG_SCREEN_WIDTH, w);
        tracker.set_reg(REG_SCREEN_HEIGHT, h);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned scr_w[6];
        int unsigned scr_h[6];
        int unsigned tx_mode[4];
        int unsigned rx_mode[4];

        // screen sizes per group: reset size, the extremes, a small one, a random one
        scr_w   = '{1024, 8, 4096, 4095, 64, 0};
        scr_h   = '{768, 32, 4096, 4095, 48, 0};
        scr_w[5] = $urandom_range(8, 4096);
        scr_h[5] = $urandom_range(32, 4096);
        // idling patterns: none, sender, receiver, both
        tx_mode = '{0, 64, 0, 37};
        rx_mode = '{0, 0, 64, 37};

        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_addr   <= REG_SCREEN_WIDTH;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_PRINT;
        char_code  <= '0;
        text_color <= '0;
        new_x      <= '0;
        new_y      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset screen size of 1024 by 768
        send_move(12'd0, 12'd0);
        send_char(8'h41, 24'hFFFFFF);       // plain glyph
        send_char(CH_SPACE, 24'h123456);    // space moves without drawing
        send_char(8'h1A, 24'h000000);       // lowest printable code
        send_char(8'h7E, 24'hABCDEF);       // highest printable code
        send_char(CH_DEL, 24'hFFFFFF);      // ignored codes from here
        send_char(8'h80, 24'hFFFFFF);
        send_char(8'hFF, 24'hFFFFFF);
        send_char(8'h00, 24'hFFFFFF);
        send_char(CH_TAB, 24'h0);
        send_char(CH_CR, 24'h0);
        send_char(CH_BS, 24'h0);            // top-left corner: nothing to blank
        send_char(8'h42, 24'h00FF00);
        send_char(CH_BS, 24'h0);            // blanks the cell just drawn
        send_char(CH_NL, 24'h0);
        send_char(CH_BS, 24'h0);            // back to the end of the line above
        send_move(12'd1000, 12'd0);
        send_char(CH_TAB, 24'h0);           // tab would pass the edge
        send_move(12'd1016, 12'd0);
        send_char(8'h45, 24'h0000FF);       // last cell that fits
        send_char(8'h46, 24'hFF0000);       // wraps to the next line
        send_move(12'd0, 12'd752);
        send_char(CH_NL, 24'h0);            // newline on the bottom row scrolls
        send_move(12'd4095, 12'd4095);
        send_char(8'h7E, 24'h800001);       // wrap plus a deep scroll
        send_move(12'd4095, 12'd4095);
        send_char(CH_BS, 24'h0);

        // random part: six screen sizes, each under all four idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            if (p % 4 == 0)
            begin
                drain();
                set_screen(scr_w[p / 4], scr_h[p / 4]);
            end
            tx_idle_pct  = tx_mode[p % 4];
            rx_stall_pct = rx_mode[p % 4];
            if (p == 0)
                hold_left = HOLD_CYCLES;
            repeat (PHASE_ITEMS)
                send_item(random_item(tracker.width_px, tracker.height_px));
        end

        drain();
        repeat (20) @(posedge clk);

        $display("%0d characters and cursor moves checked as %0d cell commands,",
                 items_sent, tracker.cells_checked);
        $display("over six screen sizes, four idling patterns and one long output hold-off");
        if (tracker.mismatches == 0 && tracker.owed() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/ttcc_pkg.sv
sv/ttcc_front.sv
sv/ttcc_queue.sv
sv/ttcc_back.sv
sv/text_console_cursor_engine_unit.sv
test/testbench.sv
